/* src/lesp_pkg.sv */
package lesp_pkg;

    localparam int GRAD_W   = 32;
    localparam int MOD_W    = 24;
    localparam int STRESS_W = 48;
    localparam int V2_W     = 96;
    localparam int ROOT_W   = V2_W / 2;

    typedef enum logic [0:0] {
        CFG_SHEAR_MOD   = 1'b0,
        CFG_LAME_LAMBDA = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [MOD_W-1:0] shear_mod;
        logic [MOD_W-1:0] lame_lambda;
    } t_cfg;

    typedef struct packed {
        logic signed [GRAD_W-1:0] xx;
        logic signed [GRAD_W-1:0] xy;
        logic signed [GRAD_W-1:0] xz;
        logic signed [GRAD_W-1:0] yx;
        logic signed [GRAD_W-1:0] yy;
        logic signed [GRAD_W-1:0] yz;
        logic signed [GRAD_W-1:0] zx;
        logic signed [GRAD_W-1:0] zy;
        logic signed [GRAD_W-1:0] zz;
    } t_grad;

    typedef struct packed {
        logic signed [STRESS_W-1:0] xx;
        logic signed [STRESS_W-1:0] yy;
        logic signed [STRESS_W-1:0] zz;
        logic signed [STRESS_W-1:0] xy;
        logic signed [STRESS_W-1:0] yz;
        logic signed [STRESS_W-1:0] zx;
    } t_stress;

endpackage

/* src/lesp_stress.sv */
module lesp_stress import lesp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_grad   i_grad,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_stress o_stress
);

    // round half up to 16 fraction bits; the result always fits 46 bits
    function automatic logic signed [STRESS_W-1:0] to_q16(input logic signed [59:0] x);
        logic signed [59:0] b;
        b = x + 60'sd8192;
        return STRESS_W'($signed(b[59:14]));
    endfunction

    // stage A: trace and shear sums
    logic                     r_vld_a;
    logic signed [33:0]       r_a_tr;
    logic signed [GRAD_W-1:0] r_a_hxx, r_a_hyy, r_a_hzz;
    logic signed [32:0]       r_a_sxy, r_a_syz, r_a_szx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tr  <= 34'(i_grad.xx) + 34'(i_grad.yy) + 34'(i_grad.zz);
            r_a_hxx <= i_grad.xx;
            r_a_hyy <= i_grad.yy;
            r_a_hzz <= i_grad.zz;
            r_a_sxy <= 33'(i_grad.xy) + 33'(i_grad.yx);
            r_a_syz <= 33'(i_grad.yz) + 33'(i_grad.zy);
            r_a_szx <= 33'(i_grad.xz) + 33'(i_grad.zx);
        end
    end

    // stage B: products with the moduli
    logic signed [MOD_W:0] c_g, c_lam;
    logic signed [58:0]    c_lt;
    logic signed [56:0]    c_dxx, c_dyy, c_dzz;
    logic signed [57:0]    c_pxy, c_pyz, c_pzx;

    assign c_g   = $signed({1'b0, i_cfg.shear_mod});
    assign c_lam = $signed({1'b0, i_cfg.lame_lambda});
    assign c_lt  = c_lam * r_a_tr;
    assign c_dxx = c_g * r_a_hxx;
    assign c_dyy = c_g * r_a_hyy;
    assign c_dzz = c_g * r_a_hzz;
    assign c_pxy = c_g * r_a_sxy;
    assign c_pyz = c_g * r_a_syz;
    assign c_pzx = c_g * r_a_szx;

    logic               r_vld_b;
    logic signed [57:0] r_b_lt;
    logic signed [56:0] r_b_dxx, r_b_dyy, r_b_dzz;
    logic signed [57:0] r_b_pxy, r_b_pyz, r_b_pzx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_lt  <= c_lt[57:0];
            r_b_dxx <= c_dxx;
            r_b_dyy <= c_dyy;
            r_b_dzz <= c_dzz;
            r_b_pxy <= c_pxy;
            r_b_pyz <= c_pyz;
            r_b_pzx <= c_pzx;
        end
    end

    // stage C: combine normal terms and round everything
    logic signed [59:0] c_xx, c_yy, c_zz;

    assign c_xx = 60'(r_b_lt) + 60'($signed({r_b_dxx, 1'b0}));
    assign c_yy = 60'(r_b_lt) + 60'($signed({r_b_dyy, 1'b0}));
    assign c_zz = 60'(r_b_lt) + 60'($signed({r_b_dzz, 1'b0}));

    logic    r_vld_c;
    t_stress r_c_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_st.xx <= to_q16(c_xx);
            r_c_st.yy <= to_q16(c_yy);
            r_c_st.zz <= to_q16(c_zz);
            r_c_st.xy <= to_q16(60'(r_b_pxy));
            r_c_st.yz <= to_q16(60'(r_b_pyz));
            r_c_st.zx <= to_q16(60'(r_b_pzx));
        end
    end

    assign o_valid  = r_vld_c;
    assign o_stress = r_c_st;

endmodule

/* src/lesp_square_sum.sv */
module lesp_square_sum import lesp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_stress         i_stress,
    output logic            o_valid,
    output logic [V2_W-1:0] o_v2,
    output t_stress         o_stress
);

    localparam int NSTG = 5;
    localparam int HALF = STRESS_W / 2;

    function automatic logic [STRESS_W-1:0] mag(input logic signed [STRESS_W:0] d);
        logic signed [STRESS_W:0] n;
        n = -d;
        return d[STRESS_W] ? n[STRESS_W-1:0] : d[STRESS_W-1:0];
    endfunction

    logic [NSTG-1:0] r_vld;
    t_stress         r_st [0:NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= i_stress;
            for (int i = 1; i < NSTG; i++) begin
                r_st[i] <= r_st[i-1];
            end
        end
    end

    // stage D: magnitudes of normal differences and shear terms
    logic signed [STRESS_W:0] c_d0, c_d1, c_d2;
    logic [STRESS_W-1:0]      r_mag [0:5];

    assign c_d0 = (STRESS_W+1)'(i_stress.xx) - (STRESS_W+1)'(i_stress.yy);
    assign c_d1 = (STRESS_W+1)'(i_stress.yy) - (STRESS_W+1)'(i_stress.zz);
    assign c_d2 = (STRESS_W+1)'(i_stress.zz) - (STRESS_W+1)'(i_stress.xx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= mag(c_d0);
            r_mag[1] <= mag(c_d1);
            r_mag[2] <= mag(c_d2);
            r_mag[3] <= mag((STRESS_W+1)'(i_stress.xy));
            r_mag[4] <= mag((STRESS_W+1)'(i_stress.yz));
            r_mag[5] <= mag((STRESS_W+1)'(i_stress.zx));
        end
    end

    // stage E: half-word partial products
    logic [STRESS_W-1:0] r_hh [0:5];
    logic [STRESS_W-1:0] r_hl [0:5];
    logic [STRESS_W-1:0] r_ll [0:5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r_hh[i] <= r_mag[i][STRESS_W-1:HALF] * r_mag[i][STRESS_W-1:HALF];
                r_hl[i] <= r_mag[i][STRESS_W-1:HALF] * r_mag[i][HALF-1:0];
                r_ll[i] <= r_mag[i][HALF-1:0] * r_mag[i][HALF-1:0];
            end
        end
    end

    // stage F: assemble squares, cross term counted twice
    logic [V2_W-1:0] r_sq [0:5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) begin
                r_sq[i] <= (V2_W'(r_hh[i]) << STRESS_W) + (V2_W'(r_hl[i]) << (HALF + 1))
                         + V2_W'(r_ll[i]);
            end
        end
    end

    // stage G: partial sums
    logic [V2_W-1:0] r_nsum, r_ssum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_ssum <= r_sq[3] + r_sq[4] + r_sq[5];
        end
    end

    // stage H: halve normal sum (always even), triple shear sum
    logic [V2_W-1:0] r_v2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v2 <= (r_nsum >> 1) + r_ssum + (r_ssum << 1);
        end
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_v2     = r_v2;
    assign o_stress = r_st[NSTG-1];

endmodule

/* src/lesp_isqrt.sv */
module lesp_isqrt import lesp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [V2_W-1:0]   i_v2,
    input  t_stress           i_stress,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_stress           o_stress
);

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic              c_vld  [0:ROOT_W-1];
    logic [REM_W-1:0]  c_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] c_root [0:ROOT_W-1];
    logic [V2_W-1:0]   c_n    [0:ROOT_W-1];
    t_stress           c_st   [0:ROOT_W-1];

    logic              r_vld  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [V2_W-1:0]   r_n    [0:ROOT_W-1];
    t_stress           r_st   [0:ROOT_W-1];

    assign c_vld[0]  = i_valid;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;
    assign c_n[0]    = i_v2;
    assign c_st[0]   = i_stress;

    // one root bit per stage, restoring form
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [TRY_W-1:0] c_cur;
        logic [TRY_W-1:0] c_try;
        logic [TRY_W:0]   c_diff;
        logic             c_fit;

        if (k > 0) begin : g_link
            assign c_vld[k]  = r_vld[k-1];
            assign c_rem[k]  = r_rem[k-1];
            assign c_root[k] = r_root[k-1];
            assign c_n[k]    = r_n[k-1];
            assign c_st[k]   = r_st[k-1];
        end

        assign c_cur  = {c_rem[k], c_n[k][V2_W-1-2*k -: 2]};
        assign c_try  = TRY_W'({c_root[k], 2'b01});
        assign c_diff = {1'b0, c_cur} - {1'b0, c_try};
        assign c_fit  = !c_diff[TRY_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_fit ? c_diff[REM_W-1:0] : c_cur[REM_W-1:0];
                r_root[k] <= {c_root[k][ROOT_W-2:0], c_fit};
                r_n[k]    <= c_n[k];
                r_st[k]   <= c_st[k];
            end
        end
    end

    assign o_valid  = r_vld[ROOT_W-1];
    assign o_root   = r_root[ROOT_W-1];
    assign o_stress = r_st[ROOT_W-1];

endmodule

/* src/linear_elastic_stress_point_core.sv */
// Isotropic linear elastic stress at one integration point. Each input beat
// carries a 3x3 displacement gradient (nine signed Q2.30 words); each output
// beat carries the six Cauchy stress components and the von Mises equivalent
// stress, all with 16 fraction bits. The core takes one beat per clock
// whenever its output is not stalled; 3 stages form the stress (trace and
// shear sums, modulus products, rounding), 5 stages form the squared
// equivalent stress, and 48 stages extract its square root one bit per stage.
// The whole pipeline advances together whenever the output register is empty
// or its beat is taken, so a stalled output holds every item in place. Write
// the shear modulus (index 0) and Lame lambda (index 1) only while idle.
module linear_elastic_stress_point_core import lesp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [0:0]           i_cfg_index,
    input  logic [MOD_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz, grad_zx, grad_zy,
    // grad_zz, 32 bits each
    input  logic [9*GRAD_W-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_zx,
    // equivalent_stress, 48 bits each
    output logic [7*STRESS_W-1:0] m_axis_tdata
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SHEAR_MOD:   r_cfg.shear_mod   <= i_cfg_data;
                CFG_LAME_LAMBDA: r_cfg.lame_lambda <= i_cfg_data;
            endcase
        end
    end

    logic  c_en;
    t_grad c_grad;

    // advance while the output register is free or being drained
    assign c_en          = m_axis_tready || !m_axis_tvalid;
    // refuse beats while in reset
    assign s_axis_tready = c_en && i_rst_n;

    assign c_grad.xx = s_axis_tdata[0*GRAD_W +: GRAD_W];
    assign c_grad.xy = s_axis_tdata[1*GRAD_W +: GRAD_W];
    assign c_grad.xz = s_axis_tdata[2*GRAD_W +: GRAD_W];
    assign c_grad.yx = s_axis_tdata[3*GRAD_W +: GRAD_W];
    assign c_grad.yy = s_axis_tdata[4*GRAD_W +: GRAD_W];
    assign c_grad.yz = s_axis_tdata[5*GRAD_W +: GRAD_W];
    assign c_grad.zx = s_axis_tdata[6*GRAD_W +: GRAD_W];
    assign c_grad.zy = s_axis_tdata[7*GRAD_W +: GRAD_W];
    assign c_grad.zz = s_axis_tdata[8*GRAD_W +: GRAD_W];

    logic    c_st_vld;
    t_stress c_st;

    lesp_stress u_stress (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (c_en),
        .i_valid  (s_axis_tvalid),
        .i_grad   (c_grad),
        .i_cfg    (r_cfg),
        .o_valid  (c_st_vld),
        .o_stress (c_st)
    );

    logic            c_sq_vld;
    logic [V2_W-1:0] c_v2;
    t_stress         c_sq_st;

    lesp_square_sum u_square_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (c_en),
        .i_valid  (c_st_vld),
        .i_stress (c_st),
        .o_valid  (c_sq_vld),
        .o_v2     (c_v2),
        .o_stress (c_sq_st)
    );

    logic [ROOT_W-1:0] c_root;
    t_stress           c_out_st;

    lesp_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (c_en),
        .i_valid  (c_sq_vld),
        .i_v2     (c_v2),
        .i_stress (c_sq_st),
        .o_valid  (m_axis_tvalid),
        .o_root   (c_root),
        .o_stress (c_out_st)
    );

    // root of a 96-bit value never exceeds 48 bits, so no clamp is needed
    assign m_axis_tdata = {STRESS_W'(c_root), c_out_st.zx, c_out_st.yz, c_out_st.xy,
                           c_out_st.zz, c_out_st.yy, c_out_st.xx};

endmodule
